@@ hdl/mmh_pkg.sv @@
// Package for the MurmurHash3 x86_32 key hasher.
// Holds state and command types, hash constants and small bit functions.
// Used by mmh_csr, mmh_ctrl, mmh_dp and murmur3_32_key_hash.
package mmh_pkg;

   localparam int unsigned CSR_ADDR_W = 2;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_SEED = 2'd0;

   localparam logic [31:0] SEED_RESET = 32'ha5a5a5a5;
   localparam logic [31:0] MIX_C1     = 32'hcc9e2d51;
   localparam logic [31:0] MIX_C2     = 32'h1b873593;
   localparam logic [31:0] FOLD_ADD   = 32'he6546b64;
   localparam logic [31:0] AVAL_M1    = 32'h85ebca6b;
   localparam logic [31:0] AVAL_M2    = 32'hc2b2ae35;
   localparam logic [2:0]  FULL_BYTES = 3'd4;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_MIX1,
      ST_MIX2,
      ST_FOLD,
      ST_AVAL1,
      ST_AVAL2,
      ST_EMIT
   } state_type;

   typedef struct packed {
      logic load;
      logic mix1;
      logic mix2;
      logic fold;
      logic aval1;
      logic aval2;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic last;
      logic out_free;
   } status_type;

   function automatic logic [31:0] rotl32(input logic [31:0] v, input int unsigned r);
      rotl32 = (v << r) | (v >> (32 - r));
   endfunction

   function automatic logic [31:0] tail_mask(input logic [1:0] nb);
      case (nb)
         2'd0:    tail_mask = 32'h00000000;
         2'd1:    tail_mask = 32'h000000ff;
         2'd2:    tail_mask = 32'h0000ffff;
         default: tail_mask = 32'h00ffffff;
      endcase
   endfunction

endpackage

@@ hdl/mmh_csr.sv @@
// Configuration register file of the key hasher: the seed register.
// Depends on mmh_pkg for the address map and reset value.
module mmh_csr import mmh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready,
   output logic [31:0]           seed
);

   logic [31:0] seed_ff;
   logic [31:0] seed_in;

   always_comb begin
      seed_in = seed_ff;
      if (csr_psel && csr_penable && csr_pwrite && csr_paddr == CSR_ADDR_SEED) begin
         seed_in = csr_pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         seed_ff <= SEED_RESET;
      end else begin
         seed_ff <= seed_in;
      end
   end

   always_comb begin
      unique case (csr_paddr)
         CSR_ADDR_SEED: csr_prdata = seed_ff;
         default:       csr_prdata = 32'd0;
      endcase
   end

   assign csr_pready = 1'b1;
   assign seed       = seed_ff;

endmodule

@@ hdl/mmh_ctrl.sv @@
// Sequencing state machine of the key hasher; depends on mmh_pkg.
// Issues one datapath command per cycle unless the output stalls.
module mmh_ctrl import mmh_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff;
   state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_MIX1;
            end
         end
         ST_MIX1: begin
            cmd.mix1 = 1'b1;
            state_in = ST_MIX2;
         end
         ST_MIX2: begin
            cmd.mix2 = 1'b1;
            state_in = ST_FOLD;
         end
         ST_FOLD: begin
            cmd.fold = 1'b1;
            state_in = status.last ? ST_AVAL1 : ST_IDLE;
         end
         ST_AVAL1: begin
            cmd.aval1 = 1'b1;
            state_in  = ST_AVAL2;
         end
         ST_AVAL2: begin
            cmd.aval2 = 1'b1;
            state_in  = ST_EMIT;
         end
         ST_EMIT: begin
            // hold until the output register is free
            if (status.out_free) begin
               cmd.emit = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

endmodule

@@ hdl/mmh_dp.sv @@
// Datapath of the key hasher: word mix, hash fold, avalanche and result register.
// Driven by mmh_ctrl commands; depends on mmh_pkg.
module mmh_dp import mmh_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  cmd_type     cmd,
   output status_type  status,
   input  logic [31:0] seed,
   input  logic [31:0] req_key_word,
   input  logic [2:0]  req_word_bytes,
   input  logic        req_last_word,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [31:0] rsp_hash_value
);

   logic [31:0] word_ff,  word_in;
   logic [2:0]  nb_ff,    nb_in;
   logic        last_ff,  last_in;
   logic [31:0] k_ff,     k_in;
   logic [31:0] hash_ff,  hash_in;
   logic [31:0] total_ff, total_in;
   logic        start_ff, start_in;
   logic [31:0] aval_ff,  aval_in;
   logic [31:0] out_ff,   out_in;
   logic        valid_ff, valid_in;

   logic [2:0]  nb_clamp;
   logic [31:0] h_base;
   logic [31:0] t_base;
   logic [31:0] h_new;
   logic [31:0] h_mix;
   logic [31:0] h_fin;

   always_comb begin
      nb_clamp = (req_word_bytes > FULL_BYTES) ? FULL_BYTES : req_word_bytes;
      h_base   = start_ff ? seed : hash_ff;
      t_base   = start_ff ? 32'd0 : total_ff;
      h_mix    = rotl32(h_base ^ k_ff, 13);
      if (nb_ff == FULL_BYTES) begin
         h_new = (h_mix << 2) + h_mix + FOLD_ADD;
      end else if (nb_ff != 3'd0) begin
         h_new = h_base ^ k_ff;
      end else begin
         h_new = h_base;
      end
      total_in = t_base + {29'd0, nb_ff};
      h_fin    = h_new ^ total_in;
   end

   always_comb begin
      word_in  = word_ff;
      nb_in    = nb_ff;
      last_in  = last_ff;
      k_in     = k_ff;
      hash_in  = hash_ff;
      start_in = start_ff;
      aval_in  = aval_ff;
      out_in   = out_ff;
      valid_in = valid_ff && !rsp_ready;
      if (cmd.load) begin
         word_in = (nb_clamp == FULL_BYTES) ? req_key_word
                                            : (req_key_word & tail_mask(nb_clamp[1:0]));
         nb_in   = nb_clamp;
         last_in = req_last_word;
      end
      if (cmd.mix1) begin
         k_in = word_ff * MIX_C1;
      end
      if (cmd.mix2) begin
         k_in = rotl32(k_ff, 15) * MIX_C2;
      end
      if (cmd.fold) begin
         hash_in  = h_new;
         start_in = last_ff;
         aval_in  = h_fin ^ (h_fin >> 16);
      end
      if (cmd.aval1) begin
         aval_in = aval_ff * AVAL_M1;
      end
      if (cmd.aval2) begin
         aval_in = (aval_ff ^ (aval_ff >> 13)) * AVAL_M2;
      end
      if (cmd.emit) begin
         out_in   = aval_ff ^ (aval_ff >> 16);
         valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         start_ff <= 1'b1;
         valid_ff <= 1'b0;
      end else begin
         start_ff <= start_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      word_ff  <= word_in;
      nb_ff    <= nb_in;
      last_ff  <= last_in;
      k_ff     <= k_in;
      hash_ff  <= hash_in;
      aval_ff  <= aval_in;
      out_ff   <= out_in;
      if (cmd.fold) begin
         total_ff <= total_in;
      end
   end

   assign status.last     = last_ff;
   assign status.out_free = !valid_ff || rsp_ready;
   assign rsp_valid       = valid_ff;
   assign rsp_hash_value  = out_ff;

endmodule

@@ hdl/murmur3_32_key_hash.sv @@
// Top level of the MurmurHash3 x86_32 key hasher.
// Instantiates mmh_csr, mmh_ctrl and mmh_dp; depends on mmh_pkg.
//
//   channel  ports                                         role
//   req      req_valid/ready, key_word, word_bytes, last   key words in
//   rsp      rsp_valid/ready, hash_value                   finished hash out
//   csr      csr_psel/penable/pwrite/paddr/pwdata/...      seed register
//
// Each item passes through capture, two multiply stages of the word mix, then fold.
// A last item then passes through the avalanche (two multiply stages, then the result
// register), and waits there while the result register stays full.
// Reset is synchronous; after it the seed is 0xa5a5a5a5 and the next item starts a key.
// A stalled result does not block the next item until its avalanche reaches the output.
module murmur3_32_key_hash import mmh_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [31:0]           req_key_word,
   input  logic [2:0]            req_word_bytes,
   input  logic                  req_last_word,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [31:0]           rsp_hash_value,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [CSR_ADDR_W-1:0] csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [31:0] seed;
   cmd_type     cmd;
   status_type  status;

   mmh_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .seed        (seed)
   );

   mmh_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mmh_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .seed           (seed),
      .req_key_word   (req_key_word),
      .req_word_bytes (req_word_bytes),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value)
   );

endmodule

@@ hdl/mmh_checker.sv @@
// Port-level checker for the key hasher, bound to murmur3_32_key_hash.
// Watches only the handshake and result ports of the top level.
module mmh_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_hash_value
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_hash_value))
      else $error("result dropped or changed while stalled");

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while previous item in progress");

   a_rsp_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> !$past(req_ready))
      else $error("result appeared without an item in progress");

   a_reset_clears: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid after reset");

endmodule

bind murmur3_32_key_hash mmh_checker u_mmh_checker (.*);

@@ dv/murmur3_32_key_hash_test.sv @@
// Self-checking testbench for murmur3_32_key_hash: streams keys through the req channel,
// writes the seed over the csr port and checks each finished hash against a local predictor.
// Depends on mmh_pkg and the murmur3_32_key_hash RTL.
module murmur3_32_key_hash_test;
   import mmh_pkg::*;

   localparam logic [31:0] SEED_INIT  = 32'ha5a5a5a5;
   localparam logic [31:0] SCRAMBLE_A = 32'hcc9e2d51;
   localparam logic [31:0] SCRAMBLE_B = 32'h1b873593;
   localparam logic [31:0] FOLD_K     = 32'he6546b64;
   localparam logic [31:0] SPREAD_A   = 32'h85ebca6b;
   localparam logic [31:0] SPREAD_B   = 32'hc2b2ae35;
   localparam int          SETTLE     = 20;

   class hash_scoreboard;
      logic [31:0] seed_reg;
      logic [31:0] run_hash;
      logic [31:0] byte_count;
      bit          key_start;
      logic [31:0] hash_q[$];
      int          errors;

      function new();
         seed_reg   = SEED_INIT;
         run_hash   = '0;
         byte_count = '0;
         key_start  = 1'b1;
         errors     = 0;
      endfunction

      function logic [31:0] rotl(logic [31:0] v, int unsigned r);
         return (v << r) | (v >> (32 - r));
      endfunction

      function logic [31:0] scramble(logic [31:0] k);
         k = k * SCRAMBLE_A;
         k = rotl(k, 15);
         k = k * SCRAMBLE_B;
         return k;
      endfunction

      function logic [31:0] finish_hash(logic [31:0] h);
         h = h ^ (h >> 16);
         h = h * SPREAD_A;
         h = h ^ (h >> 13);
         h = h * SPREAD_B;
         h = h ^ (h >> 16);
         return h;
      endfunction

      function void note_item(logic [31:0] word, logic [2:0] nb, logic last);
         logic [31:0] h;
         logic [31:0] total;
         logic [2:0]  n;
         h     = key_start ? seed_reg : run_hash;
         total = key_start ? 32'd0 : byte_count;
         n     = (nb > FULL_BYTES) ? FULL_BYTES : nb;
         if (n == FULL_BYTES) begin
            h = h ^ scramble(word);
            h = rotl(h, 13);
            h = h * 32'd5 + FOLD_K;
         end else if (n != 3'd0) begin
            h = h ^ scramble(word & ((32'd1 << (8 * n)) - 32'd1));
         end
         total = total + 32'(n);
         if (last) begin
            hash_q.push_back(finish_hash(h ^ total));
            run_hash   = '0;
            byte_count = '0;
            key_start  = 1'b1;
         end else begin
            run_hash   = h;
            byte_count = total;
            key_start  = 1'b0;
         end
      endfunction

      function void check_hash(logic [31:0] actual);
         logic [31:0] want;
         if (hash_q.size() == 0) begin
            $error("hash_value: no hash expected, actual %h", actual);
            errors++;
            return;
         end
         want = hash_q.pop_front();
         if (actual !== want) begin
            $error("hash_value: expected %h, actual %h", want, actual);
            errors++;
         end
      endfunction
   endclass

   logic                  clock          = 1'b0;
   logic                  reset          = 1'b1;
   logic                  req_valid      = 1'b0;
   logic                  req_ready;
   logic [31:0]           req_key_word   = '0;
   logic [2:0]            req_word_bytes = '0;
   logic                  req_last_word  = 1'b0;
   logic                  rsp_valid;
   logic                  rsp_ready      = 1'b0;
   logic [31:0]           rsp_hash_value;
   logic                  csr_psel       = 1'b0;
   logic                  csr_penable    = 1'b0;
   logic                  csr_pwrite     = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr      = '0;
   logic [31:0]           csr_pwdata     = '0;
   logic [31:0]           csr_prdata;
   logic                  csr_pready;

   hash_scoreboard sb = new();
   int             idle_pct   = 0;
   int             stall_pct  = 0;
   int             hold_left  = 0;
   int             items_sent = 0;

   murmur3_32_key_hash dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_key_word   (req_key_word),
      .req_word_bytes (req_word_bytes),
      .req_last_word  (req_last_word),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_hash_value (rsp_hash_value),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   always #5 clock = ~clock;

   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left = hold_left - 1;
      end else begin
         rsp_ready <= ($urandom_range(99) >= stall_pct);
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         sb.check_hash(rsp_hash_value);
      end
   end

   task automatic send_item(input logic [31:0] word, input logic [2:0] nb, input logic last);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid      <= 1'b1;
      req_key_word   <= word;
      req_word_bytes <= nb;
      req_last_word  <= last;
      do @(posedge clock); while (!req_ready);
      sb.note_item(word, nb, last);
      items_sent++;
   endtask

   task automatic csr_access(input logic write, input logic [31:0] wdata,
                             input logic [31:0] rdata_want);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= CSR_ADDR_SEED;
      csr_pwdata  <= wdata;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (!write && csr_prdata !== rdata_want) begin
         $error("seed: expected %h, actual %h", rdata_want, csr_prdata);
         sb.errors++;
      end
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic set_seed(input logic [31:0] value);
      csr_access(1'b1, value, '0);
      sb.seed_reg = value;
      csr_access(1'b0, '0, value);
   endtask

   task automatic drain();
      req_valid <= 1'b0;
      while (sb.hash_q.size() != 0) @(posedge clock);
      repeat (SETTLE) @(posedge clock);
   endtask

   function automatic logic [31:0] pick_word();
      case ($urandom_range(15))
         0:       return 32'h0000_0000;
         1:       return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   task automatic send_random_key();
      int         len;
      bit         noisy;
      logic [2:0] nb;
      noisy = ($urandom_range(99) < 15);
      len   = ($urandom_range(9) == 0) ? $urandom_range(20, 7) : $urandom_range(5);
      for (int i = 0; i < len; i++) begin
         nb = (noisy && $urandom_range(3) == 0) ? 3'($urandom_range(7)) : FULL_BYTES;
         send_item(pick_word(), nb, 1'b0);
      end
      nb = noisy ? 3'($urandom_range(7)) : 3'($urandom_range(4));
      send_item(pick_word(), nb, 1'b1);
   endtask

   task automatic run_phase(input logic [31:0] seed, input int idle, input int stall,
                            input int quota, input int hold);
      int stop_at;
      set_seed(seed);
      idle_pct  = idle;
      stall_pct = stall;
      hold_left = hold;
      stop_at   = items_sent + quota;
      while (items_sent < stop_at) send_random_key();
      drain();
   endtask

   initial begin
      #5_000_000;
      $display("simulation failed");
      $finish;
   end

   initial begin
      int waited;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      csr_access(1'b0, '0, SEED_INIT);

      // empty key, short tails with garbage above the valid bytes, then two full-word keys
      send_item(32'h0000_0000, 3'd0, 1'b1);
      send_item(32'hffff_ffff, 3'd1, 1'b1);
      send_item(32'hffff_ffff, 3'd2, 1'b1);
      send_item(32'hffff_ffff, 3'd3, 1'b1);
      send_item(32'hffff_ffff, FULL_BYTES, 1'b1);
      send_item(32'h0000_0000, FULL_BYTES, 1'b1);
      // byte counts above four clamp to a full word
      send_item(32'h1234_5678, 3'd5, 1'b1);
      send_item(32'h1234_5678, 3'd6, 1'b1);
      send_item(32'h1234_5678, 3'd7, 1'b1);
      // zero bytes inside a key
      send_item(32'hdead_beef, FULL_BYTES, 1'b0);
      send_item(32'hcafe_f00d, 3'd0, 1'b0);
      send_item(32'h0bad_c0de, FULL_BYTES, 1'b1);
      // partial word before the end
      send_item(32'h8765_4321, 3'd2, 1'b0);
      send_item(32'h5555_aaaa, FULL_BYTES, 1'b0);
      send_item(32'haaaa_5555, 3'd3, 1'b1);
      // finalize on an empty last item
      send_item(32'h0f0f_0f0f, FULL_BYTES, 1'b0);
      send_item(32'hf0f0_f0f0, 3'd0, 1'b1);
      drain();

      run_phase(32'h0000_0000, 0, 0, 300, 0);
      run_phase(32'hffff_ffff, 78, 0, 300, 0);
      run_phase($urandom, 0, 78, 300, 400);
      run_phase($urandom, 27, 27, 300, 0);
      run_phase(SEED_INIT, 0, 0, 300, 300);

      waited = 0;
      while (sb.hash_q.size() != 0 && waited < 5000) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE) @(posedge clock);
      if (sb.hash_q.size() != 0) begin
         $error("hash_value: %0d expected hashes never arrived", sb.hash_q.size());
         sb.errors++;
      end
      if (sb.errors == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule

@@ murmur3_32_key_hash.f @@
hdl/mmh_pkg.sv
hdl/mmh_csr.sv
hdl/mmh_ctrl.sv
hdl/mmh_dp.sv
hdl/murmur3_32_key_hash.sv
hdl/mmh_checker.sv
dv/murmur3_32_key_hash_test.sv
